// ===== design/midpoint_ellipse_rasterizer_assert.svh =====
// ----------------------------------------------------------------------------
// midpoint ellipse rasterizer assertion macros
// concurrent check helpers, sampled on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// same-cycle implication
`define MER_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("midpoint_ellipse_rasterizer: assertion failed");

// next-cycle implication
`define MER_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("midpoint_ellipse_rasterizer: assertion failed");

`endif

// ===== design/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// widths and constants shared by the ellipse rasterizer modules
// ----------------------------------------------------------------------------
package mer_pkg;

  // coordinate and step widths
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned XY_W       = COORD_BITS + 1;
  localparam int unsigned SQ_W       = 2 * COORD_BITS;
  localparam int unsigned PT_W       = 15;

  // shared multiplier operand and product widths
  localparam int unsigned MA_W   = 2 * (XY_W + 1);
  localparam int unsigned MB_W   = SQ_W;
  localparam int unsigned PROD_W = MA_W + MB_W;

  // decision variable and scratch register widths
  localparam int unsigned DEC_W = 56;
  localparam int unsigned T_W   = SQ_W + XY_W + 1;

  // scale factors of the decision update
  localparam int unsigned TIMES4_SHIFT = 2;
  localparam int unsigned TIMES8_SHIFT = 3;
  localparam int unsigned MUL_THREE    = 3;

endpackage

// ===== design/mer_mul.sv =====
// ----------------------------------------------------------------------------
// mer_mul
// shared unsigned multiplier with a registered product
// ----------------------------------------------------------------------------
module mer_mul (
  input  logic                        clk,
  input  logic [mer_pkg::MA_W-1:0]    mul_a,
  input  logic [mer_pkg::MB_W-1:0]    mul_b,
  output logic [mer_pkg::PROD_W-1:0]  prod
);
  import mer_pkg::*;

  logic [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  assign prod = prod_r;

endmodule

// ===== design/midpoint_ellipse_rasterizer.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// integer midpoint ellipse outline generator, one shared multiplier
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall): req_type 0 starts a new ellipse from
//   center and second vertex, req_type 1 advances the outline one step.
//   result channel (out_valid / out_stall): four mirrored points per run,
//   last_of_run on the fourth, outline_done on the final point of the ellipse.
//   a step after the outline is done is accepted in idle and yields nothing.
// timing
//   a small sequencer drives one 28x24 multiplier, one product per cycle,
//   and one 56-bit accumulator; that multiplier sets the item time.
//   start runs ST0 to ST4, a region 1 step R1_0 to R1_4, a region 2 step
//   R2_0 to R2_3; the step that enters region 2 runs R1_0 to R1_2, E0 to
//   E5 and R2_0 to R2_3. then EM0 to EM3 hand out the points and the
//   sequencer returns to idle; no new request is taken before that.
// reset / stall
//   synchronous active-low reset empties the output register and marks the
//   outline finished. in_stall is high from acceptance until the last point
//   of the run is in the output register; a stalled receiver freezes the
//   sequencer in the emit phase and the held point stays on the port.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_assert.svh"

module midpoint_ellipse_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  logic [mer_pkg::COORD_BITS-1:0]     in_center_x,
  input  logic [mer_pkg::COORD_BITS-1:0]     in_center_y,
  input  logic [mer_pkg::COORD_BITS-1:0]     in_edge_x,
  input  logic [mer_pkg::COORD_BITS-1:0]     in_edge_y,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mer_pkg::PT_W-1:0]    out_point_x,
  output logic signed [mer_pkg::PT_W-1:0]    out_point_y,
  output logic                               out_last_of_run,
  output logic                               out_outline_done
);
  import mer_pkg::*;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_ST0  = 5'd1;   // a*a
  localparam logic [4:0] S_ST1  = 5'd2;   // b*b
  localparam logic [4:0] S_ST2  = 5'd3;   // aa*b, d = aa
  localparam logic [4:0] S_ST3  = 5'd4;   // d -= 4*aa*b
  localparam logic [4:0] S_ST4  = 5'd5;   // d += 4*bb
  localparam logic [4:0] S_R1_0 = 5'd6;   // bb*(x+1)
  localparam logic [4:0] S_R1_1 = 5'd7;   // aa*(2y-1)
  localparam logic [4:0] S_R1_2 = 5'd8;   // slope test
  localparam logic [4:0] S_R1_3 = 5'd9;   // d += 4*bb*(2x+3)
  localparam logic [4:0] S_R1_4 = 5'd10;  // d -= 4*aa*(2y-2)
  localparam logic [4:0] S_E0   = 5'd11;  // (2x+1)^2
  localparam logic [4:0] S_E1   = 5'd12;  // (y-1)^2
  localparam logic [4:0] S_E2   = 5'd13;  // bb*(2x+1)^2
  localparam logic [4:0] S_E3   = 5'd14;  // d = bb*(2x+1)^2
  localparam logic [4:0] S_E4   = 5'd15;  // d += 4*aa*(y-1)^2
  localparam logic [4:0] S_E5   = 5'd16;  // d -= 4*aa*bb
  localparam logic [4:0] S_R2_0 = 5'd17;  // sign, bb*(2x+2)
  localparam logic [4:0] S_R2_1 = 5'd18;  // d += 4*bb*(2x+2) if negative
  localparam logic [4:0] S_R2_2 = 5'd19;  // d -= 8*aa*y
  localparam logic [4:0] S_R2_3 = 5'd20;  // d += 12*aa
  localparam logic [4:0] S_EM0  = 5'd21;  // (+x,+y)
  localparam logic [4:0] S_EM1  = 5'd22;  // (-x,+y)
  localparam logic [4:0] S_EM2  = 5'd23;  // (+x,-y)
  localparam logic [4:0] S_EM3  = 5'd24;  // (-x,-y)

  // control state
  logic [4:0] state_r, state_nxt;
  logic       finished_r, finished_nxt;
  logic       region2_r, region2_nxt;
  logic       out_valid_r, out_valid_nxt;

  // outline state and scratch
  logic [COORD_BITS-1:0] cx_r, cx_nxt;
  logic [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [SQ_W-1:0]       aa_r, aa_nxt;
  logic [SQ_W-1:0]       bb_r, bb_nxt;
  logic [XY_W-1:0]       step_x_r, step_x_nxt;
  logic [XY_W-1:0]       step_y_r, step_y_nxt;
  logic [DEC_W-1:0]      decision_r, decision_nxt;
  logic                  neg_r, neg_nxt;
  logic [T_W-1:0]        t_r, t_nxt;

  // output register
  logic [PT_W-1:0] out_x_r, out_x_nxt;
  logic [PT_W-1:0] out_y_r, out_y_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_done_r, out_done_nxt;

  // shared multiplier
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;

  // accumulator control
  logic             acc_en;
  logic             acc_load;
  logic             acc_sub;
  logic [DEC_W-1:0] acc_mag;
  logic [DEC_W-1:0] acc_base;
  logic [DEC_W-1:0] acc_term;

  // derived step terms
  logic [COORD_BITS-1:0] a_abs;
  logic [COORD_BITS-1:0] b_abs;
  logic [XY_W:0]         x_p1;
  logic [XY_W:0]         x2_p1;
  logic [XY_W:0]         x2_p2;
  logic [XY_W:0]         x2_p3;
  logic [XY_W:0]         y2_m1;
  logic [XY_W:0]         y2_m2;
  logic [XY_W-1:0]       y_m1;
  logic                  slope;
  logic                  out_free;

  // mirrored coordinates, wrapped to the point width
  logic [PT_W-1:0] px;
  logic [PT_W-1:0] mx;
  logic [PT_W-1:0] py;
  logic [PT_W-1:0] my;

  mer_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod)
  );

  assign a_abs = (in_edge_x >= in_center_x) ? (in_edge_x - in_center_x)
                                            : (in_center_x - in_edge_x);
  assign b_abs = (in_edge_y >= in_center_y) ? (in_edge_y - in_center_y)
                                            : (in_center_y - in_edge_y);

  assign x_p1  = {1'b0, step_x_r} + (XY_W+1)'(1);
  assign x2_p1 = {step_x_r, 1'b0} + (XY_W+1)'(1);
  assign x2_p2 = {step_x_r, 1'b0} + (XY_W+1)'(2);
  assign x2_p3 = {step_x_r, 1'b0} + (XY_W+1)'(3);
  assign y2_m1 = {step_y_r, 1'b0} - (XY_W+1)'(1);
  assign y2_m2 = {step_y_r, 1'b0} - (XY_W+1)'(2);
  assign y_m1  = step_y_r - XY_W'(1);

  // region 1 continues while 2*bb*(x+1) < aa*(2y-1) and y is nonzero
  assign slope = (step_y_r != '0) && (PROD_W'({t_r, 1'b0}) < prod);

  assign px = PT_W'(cx_r) + PT_W'(step_x_r);
  assign mx = PT_W'(cx_r) - PT_W'(step_x_r);
  assign py = PT_W'(cy_r) + PT_W'(step_y_r);
  assign my = PT_W'(cy_r) - PT_W'(step_y_r);

  // output register can take a point when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  // single 56-bit add/subtract into the decision register, which wraps
  assign acc_base = acc_load ? '0 : decision_r;
  assign acc_term = acc_sub ? (~acc_mag + DEC_W'(1)) : acc_mag;

  always_comb begin
    state_nxt    = state_r;
    finished_nxt = finished_r;
    region2_nxt  = region2_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    aa_nxt       = aa_r;
    bb_nxt       = bb_r;
    step_x_nxt   = step_x_r;
    step_y_nxt   = step_y_r;
    neg_nxt      = neg_r;
    t_nxt        = t_r;
    mul_a        = '0;
    mul_b        = '0;
    acc_en       = 1'b0;
    acc_load     = 1'b0;
    acc_sub      = 1'b0;
    acc_mag      = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_last_nxt = out_last_r;
    out_done_nxt = out_done_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_req_type) begin
            // new ellipse; semi-axis a waits in scratch, b becomes y
            cx_nxt      = in_center_x;
            cy_nxt      = in_center_y;
            t_nxt       = T_W'(a_abs);
            step_x_nxt  = '0;
            step_y_nxt  = XY_W'(b_abs);
            region2_nxt = 1'b0;
            state_nxt   = S_ST0;
          end else if (!finished_r) begin
            state_nxt = region2_r ? S_R2_0 : S_R1_0;
          end
        end
      end
      S_ST0: begin
        mul_a     = MA_W'(t_r[COORD_BITS-1:0]);
        mul_b     = MB_W'(t_r[COORD_BITS-1:0]);
        state_nxt = S_ST1;
      end
      S_ST1: begin
        aa_nxt    = prod[SQ_W-1:0];
        mul_a     = MA_W'(step_y_r);
        mul_b     = MB_W'(step_y_r);
        state_nxt = S_ST2;
      end
      S_ST2: begin
        bb_nxt    = prod[SQ_W-1:0];
        mul_a     = MA_W'(step_y_r);
        mul_b     = aa_r;
        acc_en    = 1'b1;
        acc_load  = 1'b1;
        acc_mag   = DEC_W'(aa_r);
        state_nxt = S_ST3;
      end
      S_ST3: begin
        acc_en    = 1'b1;
        acc_sub   = 1'b1;
        acc_mag   = DEC_W'(prod) << TIMES4_SHIFT;
        state_nxt = S_ST4;
      end
      S_ST4: begin
        acc_en    = 1'b1;
        acc_mag   = DEC_W'(bb_r) << TIMES4_SHIFT;
        state_nxt = S_EM0;
      end
      S_R1_0: begin
        mul_a     = MA_W'(x_p1);
        mul_b     = bb_r;
        state_nxt = S_R1_1;
      end
      S_R1_1: begin
        t_nxt     = prod[T_W-1:0];
        mul_a     = MA_W'(y2_m1);
        mul_b     = aa_r;
        state_nxt = S_R1_2;
      end
      S_R1_2: begin
        if (slope) begin
          // sign is taken before the update touches d
          neg_nxt   = decision_r[DEC_W-1];
          mul_a     = MA_W'(x2_p3);
          mul_b     = bb_r;
          state_nxt = S_R1_3;
        end else begin
          state_nxt = S_E0;
        end
      end
      S_R1_3: begin
        acc_en    = 1'b1;
        acc_mag   = DEC_W'(prod) << TIMES4_SHIFT;
        mul_a     = MA_W'(y2_m2);
        mul_b     = aa_r;
        state_nxt = S_R1_4;
      end
      S_R1_4: begin
        if (!neg_r) begin
          acc_en     = 1'b1;
          acc_sub    = 1'b1;
          acc_mag    = DEC_W'(prod) << TIMES4_SHIFT;
          step_y_nxt = step_y_r - XY_W'(1);
        end
        step_x_nxt = step_x_r + XY_W'(1);
        state_nxt  = S_EM0;
      end
      S_E0: begin
        mul_a     = MA_W'(x2_p1);
        mul_b     = MB_W'(x2_p1);
        state_nxt = S_E1;
      end
      S_E1: begin
        t_nxt     = prod[T_W-1:0];
        mul_a     = MA_W'(y_m1);
        mul_b     = MB_W'(y_m1);
        state_nxt = S_E2;
      end
      S_E2: begin
        // (2x+1)^2 goes to the multiplier while (y-1)^2 takes its place
        t_nxt     = prod[T_W-1:0];
        mul_a     = t_r[MA_W-1:0];
        mul_b     = bb_r;
        state_nxt = S_E3;
      end
      S_E3: begin
        acc_en    = 1'b1;
        acc_load  = 1'b1;
        acc_mag   = DEC_W'(prod);
        mul_a     = MA_W'(aa_r);
        mul_b     = t_r[MB_W-1:0];
        state_nxt = S_E4;
      end
      S_E4: begin
        acc_en    = 1'b1;
        acc_mag   = DEC_W'(prod) << TIMES4_SHIFT;
        mul_a     = MA_W'(aa_r);
        mul_b     = bb_r;
        state_nxt = S_E5;
      end
      S_E5: begin
        acc_en      = 1'b1;
        acc_sub     = 1'b1;
        acc_mag     = DEC_W'(prod) << TIMES4_SHIFT;
        region2_nxt = 1'b1;
        state_nxt   = S_R2_0;
      end
      S_R2_0: begin
        neg_nxt   = decision_r[DEC_W-1];
        mul_a     = MA_W'(x2_p2);
        mul_b     = bb_r;
        state_nxt = S_R2_1;
      end
      S_R2_1: begin
        if (neg_r) begin
          acc_en  = 1'b1;
          acc_mag = DEC_W'(prod) << TIMES4_SHIFT;
        end
        mul_a     = MA_W'(step_y_r);
        mul_b     = aa_r;
        state_nxt = S_R2_2;
      end
      S_R2_2: begin
        acc_en    = 1'b1;
        acc_sub   = 1'b1;
        acc_mag   = DEC_W'(prod) << TIMES8_SHIFT;
        mul_a     = MA_W'(MUL_THREE);
        mul_b     = aa_r;
        state_nxt = S_R2_3;
      end
      S_R2_3: begin
        // 12*aa as 4 * (3*aa)
        acc_en     = 1'b1;
        acc_mag    = DEC_W'(prod) << TIMES4_SHIFT;
        if (neg_r) begin
          step_x_nxt = step_x_r + XY_W'(1);
        end
        step_y_nxt = step_y_r - XY_W'(1);
        state_nxt  = S_EM0;
      end
      S_EM0: begin
        finished_nxt = (step_y_r == '0);
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px;
          out_y_nxt     = py;
          out_last_nxt  = 1'b0;
          out_done_nxt  = 1'b0;
          state_nxt     = S_EM1;
        end
      end
      S_EM1: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = mx;
          out_y_nxt     = py;
          out_last_nxt  = 1'b0;
          out_done_nxt  = 1'b0;
          state_nxt     = S_EM2;
        end
      end
      S_EM2: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = px;
          out_y_nxt     = my;
          out_last_nxt  = 1'b0;
          out_done_nxt  = 1'b0;
          state_nxt     = S_EM3;
        end
      end
      S_EM3: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = mx;
          out_y_nxt     = my;
          out_last_nxt  = 1'b1;
          out_done_nxt  = (step_y_r == '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign decision_nxt = acc_en ? (acc_base + acc_term) : decision_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      finished_r  <= 1'b1;
      region2_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      finished_r  <= finished_nxt;
      region2_r   <= region2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    aa_r       <= aa_nxt;
    bb_r       <= bb_nxt;
    step_x_r   <= step_x_nxt;
    step_y_r   <= step_y_nxt;
    decision_r <= decision_nxt;
    neg_r      <= neg_nxt;
    t_r        <= t_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_point_x      = out_x_r;
  assign out_point_y      = out_y_r;
  assign out_last_of_run  = out_last_r;
  assign out_outline_done = out_done_r;

  // a point marked as end of outline always closes its run
  `MER_ASSERT_SAME(a_done_is_last, out_valid && out_outline_done, out_last_of_run)
  // a start transaction always occupies the sequencer on the next cycle
  `MER_ASSERT_NEXT(a_start_busy, in_valid && !in_stall && !in_req_type, in_stall)
  // the step position holds while its four mirrored points are handed out
  `MER_ASSERT_NEXT(a_emit_stable,
    state_r == S_EM1 || state_r == S_EM2 || state_r == S_EM3,
    $stable(step_x_r) && $stable(step_y_r))

endmodule

// ===== bench/mer_bench_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_bench_pkg
// request codes shared by the ellipse rasterizer bench modules
// ----------------------------------------------------------------------------
package mer_bench_pkg;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_kind_t;

endpackage

// ===== bench/midpoint_ellipse_rasterizer_checker.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_checker
// watches both channels, predicts the mirrored outline points of every
// accepted request and compares each point that leaves the block in order
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_center_x,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_center_y,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_edge_x,
  input  logic [mer_pkg::COORD_BITS-1:0]    in_edge_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [mer_pkg::PT_W-1:0]   out_point_x,
  input  logic signed [mer_pkg::PT_W-1:0]   out_point_y,
  input  logic                              out_last_of_run,
  input  logic                              out_outline_done,
  output int                                fail_count,
  output int                                pending_points,
  output int                                drawn_items
);
  import mer_pkg::*;
  import mer_bench_pkg::*;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic                   last;
    logic                   done;
  } outline_point_t;

  outline_point_t expected_points[$];

  // predicted outline state
  logic [COORD_BITS-1:0]   ctr_x, ctr_y;
  longint                  a_sq, b_sq;
  logic [XY_W-1:0]         cur_x, cur_y;
  logic signed [DEC_W-1:0] dec;
  logic                    region_two;
  logic                    outline_over;
  int                      mismatches;
  int                      drawn;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic queue_mirrored_points();
    logic [PT_W-1:0] px, mx, py, my;
    outline_point_t  pt;
    px = PT_W'(ctr_x) + PT_W'(cur_x);
    mx = PT_W'(ctr_x) - PT_W'(cur_x);
    py = PT_W'(ctr_y) + PT_W'(cur_y);
    my = PT_W'(ctr_y) - PT_W'(cur_y);
    outline_over = (cur_y == 0);
    for (int k = 0; k < 4; k++) begin
      pt.x    = (k % 2 == 0) ? px : mx;
      pt.y    = (k < 2) ? py : my;
      pt.last = (k == 3);
      pt.done = (k == 3) && outline_over;
      expected_points.insert(expected_points.size(), pt);
    end
    drawn++;
  endtask

  task automatic advance_outline(input logic req, input logic [COORD_BITS-1:0] c_x,
                                 input logic [COORD_BITS-1:0] c_y,
                                 input logic [COORD_BITS-1:0] e_x,
                                 input logic [COORD_BITS-1:0] e_y);
    longint sa, sb, x, y, t;
    logic   slope;
    if (req == REQ_START) begin
      sa = (e_x >= c_x) ? e_x - c_x : c_x - e_x;
      sb = (e_y >= c_y) ? e_y - c_y : c_y - e_y;
      ctr_x      = c_x;
      ctr_y      = c_y;
      a_sq       = sa * sa;
      b_sq       = sb * sb;
      cur_x      = '0;
      cur_y      = XY_W'(sb);
      t          = 4 * b_sq - 4 * a_sq * sb + a_sq;
      dec        = t[DEC_W-1:0];
      region_two = 1'b0;
      queue_mirrored_points();
      return;
    end
    // steps after the outline is closed are swallowed
    if (outline_over) return;
    x = cur_x;
    y = cur_y;
    if (!region_two) begin
      slope = (y != 0) && (2 * b_sq * (x + 1) < a_sq * (2 * y - 1));
      if (slope) begin
        if (dec[DEC_W-1]) begin
          t = longint'(dec) + 4 * b_sq * (2 * x + 3);
        end else begin
          t = longint'(dec) + 4 * b_sq * (2 * x + 3) - 4 * a_sq * (2 * y - 2);
          y--;
        end
        x++;
        dec   = t[DEC_W-1:0];
        cur_x = XY_W'(x);
        cur_y = XY_W'(y);
        queue_mirrored_points();
        return;
      end
      // slope test failed: switch regions and re-seed the decision term
      region_two = 1'b1;
      t   = b_sq * (4 * x * x + 4 * x + 1) + a_sq * 4 * (y - 1) * (y - 1) - 4 * a_sq * b_sq;
      dec = t[DEC_W-1:0];
    end
    if (dec[DEC_W-1]) begin
      t = longint'(dec) + 4 * b_sq * (2 * x + 2) + 12 * a_sq - 8 * a_sq * y;
      x++;
    end else begin
      t = longint'(dec) + 12 * a_sq - 8 * a_sq * y;
    end
    y--;
    dec   = t[DEC_W-1:0];
    cur_x = XY_W'(x);
    cur_y = XY_W'(y);
    queue_mirrored_points();
  endtask

  always @(posedge clk) begin
    outline_point_t want;
    if (!rst_n) begin
      expected_points.delete();
      ctr_x        = '0;
      ctr_y        = '0;
      a_sq         = 0;
      b_sq         = 0;
      cur_x        = '0;
      cur_y        = '0;
      dec          = '0;
      region_two   = 1'b0;
      outline_over = 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("point (%0d,%0d) with nothing expected",
                                    out_point_x, out_point_y));
        end else begin
          want = expected_points.pop_front();
          if (out_point_x !== want.x)
            report_mismatch($sformatf("point_x expected %0d got %0d", want.x, out_point_x));
          if (out_point_y !== want.y)
            report_mismatch($sformatf("point_y expected %0d got %0d", want.y, out_point_y));
          if (out_last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run expected %0b got %0b",
                                      want.last, out_last_of_run));
          if (out_outline_done !== want.done)
            report_mismatch($sformatf("outline_done expected %0b got %0b",
                                      want.done, out_outline_done));
        end
      end
      if (in_valid && !in_stall)
        advance_outline(in_req_type, in_center_x, in_center_y, in_edge_x, in_edge_y);
    end
    fail_count     <= mismatches;
    pending_points <= expected_points.size();
    drawn_items    <= drawn;
  end

endmodule

// ===== bench/midpoint_ellipse_rasterizer_tb.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_tb
// drives start and step requests into the ellipse rasterizer with random
// gaps and back-pressure; the checker beside the block predicts every point
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb;
  import mer_pkg::*;
  import mer_bench_pkg::*;

  // generous cycle ceiling, far above the slowest legal run
  localparam int CYCLE_LIMIT  = 400000;
  // request transactions wanted in the whole run
  localparam int TARGET_ITEMS = 410;

  logic                   clk;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_stall;
  logic                   in_req_type     = REQ_STEP;
  logic [COORD_BITS-1:0]  in_center_x     = '0;
  logic [COORD_BITS-1:0]  in_center_y     = '0;
  logic [COORD_BITS-1:0]  in_edge_x       = '0;
  logic [COORD_BITS-1:0]  in_edge_y       = '0;
  logic                   out_valid;
  logic                   out_stall       = 1'b0;
  logic signed [PT_W-1:0] out_point_x;
  logic signed [PT_W-1:0] out_point_y;
  logic                   out_last_of_run;
  logic                   out_outline_done;

  // no idling on either side while this is set
  logic                   quiet           = 1'b0;
  int                     cycles          = 0;
  int                     items_sent      = 0;
  int                     fail_count;
  int                     pending_points;
  int                     drawn_items;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  midpoint_ellipse_rasterizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_edge_x        (in_edge_x),
    .in_edge_y        (in_edge_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_run  (out_last_of_run),
    .out_outline_done (out_outline_done)
  );

  midpoint_ellipse_rasterizer_checker outline_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_edge_x        (in_edge_x),
    .in_edge_y        (in_edge_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_run  (out_last_of_run),
    .out_outline_done (out_outline_done),
    .fail_count       (fail_count),
    .pending_points   (pending_points),
    .drawn_items      (drawn_items)
  );

  // receiver back-pressure: roughly one stalled cycle in five
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 19);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one request transaction, with an optional idle gap in front of it;
  // returns right after the accepting edge
  task automatic send_item(input req_kind_t kind,
                           input logic [COORD_BITS-1:0] c_x,
                           input logic [COORD_BITS-1:0] c_y,
                           input logic [COORD_BITS-1:0] e_x,
                           input logic [COORD_BITS-1:0] e_y);
    // each cycle the sender idles with a chance of about one in five
    while (!quiet && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_center_x <= c_x;
    in_center_y <= c_y;
    in_edge_x   <= e_x;
    in_edge_y   <= e_y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // step request; the coordinate fields are don't-care so they carry noise
  task automatic send_step();
    send_item(REQ_STEP, COORD_BITS'($urandom()), COORD_BITS'($urandom()),
              COORD_BITS'($urandom()), COORD_BITS'($urandom()));
  endtask

  // hold the sender off until every predicted point has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points != 0);
  endtask

  initial begin
    int kind, c_x, c_y, e_x, e_y, ax, by, n_steps;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---------------- directed part ----------------
    // step straight out of reset: nothing to draw
    send_step();
    // flat ellipse, b = 0: the start run closes the outline
    send_item(REQ_START, 12'd100, 12'd200, 12'd150, 12'd200);
    send_step();
    // zero-width ellipse, a = 0: drops into region 2 at once
    send_item(REQ_START, 12'd500, 12'd500, 12'd500, 12'd503);
    repeat (4) send_step();
    // largest axes from the origin, lower mirrors wrap negative
    send_item(REQ_START, 12'd0, 12'd0, 12'hfff, 12'hfff);
    repeat (3) send_step();
    // restart while the previous outline is still open
    send_item(REQ_START, 12'hfff, 12'hfff, 12'd0, 12'd0);
    repeat (2) send_step();
    // small ellipse through both regions to the end, plus three spare steps
    send_item(REQ_START, 12'd2048, 12'd1024, 12'd2051, 12'd1026);
    repeat (6) send_step();
    // degenerate point ellipse
    send_item(REQ_START, 12'hfff, 12'd0, 12'hfff, 12'd0);
    // unit circle in the corner
    send_item(REQ_START, 12'd0, 12'hfff, 12'd1, 12'hffe);
    repeat (2) send_step();

    wait_for_drain();

    // ---------------- random part ----------------
    while (items_sent < TARGET_ITEMS) begin
      // one long stretch with both sides streaming
      quiet <= (drawn_items >= 150 && drawn_items < 250);

      c_x  = $urandom_range(0, 4095);
      c_y  = $urandom_range(0, 4095);
      kind = $urandom_range(0, 99);
      if (kind < 95) begin
        // mostly small outlines so they run to completion
        ax = (kind < 80) ? $urandom_range(0, 12) : $urandom_range(0, 100);
        by = (kind < 80) ? $urandom_range(0, 12) : $urandom_range(0, 100);
        e_x = (($urandom_range(0, 1) && c_x + ax <= 4095) || c_x < ax) ? c_x + ax : c_x - ax;
        e_y = (($urandom_range(0, 1) && c_y + by <= 4095) || c_y < by) ? c_y + by : c_y - by;
      end else begin
        // full-range vertex, only partly walked
        e_x = $urandom_range(0, 4095);
        e_y = $urandom_range(0, 4095);
        ax  = (e_x >= c_x) ? e_x - c_x : c_x - e_x;
        by  = (e_y >= c_y) ? e_y - c_y : c_y - e_y;
      end

      // occasional stray step ahead of the start
      if ($urandom_range(0, 99) < 5) send_step();

      send_item(REQ_START, COORD_BITS'(c_x), COORD_BITS'(c_y),
                COORD_BITS'(e_x), COORD_BITS'(e_y));

      // usually walk the whole outline, sometimes abandon it midway
      if ($urandom_range(0, 99) < 85) n_steps = ax + by + $urandom_range(0, 2);
      else n_steps = $urandom_range(0, ax + by);
      if (n_steps > 40) n_steps = 40;
      for (int i = 0; i < n_steps && items_sent < TARGET_ITEMS; i++) send_step();

      if ($urandom_range(0, 99) < 5) wait_for_drain();
    end

    quiet <= 1'b0;
    wait_for_drain();
    // let any stray late point show up before the verdict
    repeat (60) @(posedge clk);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/mer_pkg.sv
design/mer_mul.sv
design/midpoint_ellipse_rasterizer.sv
bench/mer_bench_pkg.sv
bench/midpoint_ellipse_rasterizer_checker.sv
bench/midpoint_ellipse_rasterizer_tb.sv
